[hw/rtl/rotation_matrix_compose_apply_core_macros.svh]
// assertion macros used by the checker file
`ifndef ROTATION_MATRIX_COMPOSE_APPLY_CORE_MACROS_SVH
`define ROTATION_MATRIX_COMPOSE_APPLY_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define RMCA_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rmca check failed");

// next-cycle implication, disabled during reset
`define RMCA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rmca check failed");

`endif

[hw/rtl/rmca_pkg.sv]
// ---------------------------------------------------------------------------
// rmca_pkg
// types, widths, codes and helper functions of the rotation matrix core
// ---------------------------------------------------------------------------
package rmca_pkg;

	localparam int COEF_FRAC_BITS = 16;
	localparam int VEC_WIDTH      = 32;

	localparam int MAT_W   = COEF_FRAC_BITS + 2;
	localparam int COEF_W  = MAT_W + 1;
	localparam int OPB_W   = (VEC_WIDTH > COEF_W) ? VEC_WIDTH : COEF_W;
	localparam int PROD_W  = MAT_W + OPB_W;
	localparam int RND_W   = PROD_W - COEF_FRAC_BITS;
	localparam int SUM_W   = RND_W + 2;
	localparam int IDX_W   = 4;

	typedef logic signed [MAT_W-1:0]     mat_t;
	typedef logic signed [COEF_W-1:0]    coef_t;
	typedef logic signed [VEC_WIDTH-1:0] vec_t;

	localparam mat_t  MAT_ONE  = mat_t'(1) <<< COEF_FRAC_BITS;
	localparam mat_t  MAT_ZERO = '0;
	localparam mat_t  MAT_MAX  = {1'b0, {(MAT_W-1){1'b1}}};
	localparam mat_t  MAT_MIN  = {1'b1, {(MAT_W-1){1'b0}}};
	localparam coef_t COEF_ONE = coef_t'(1) <<< COEF_FRAC_BITS;
	localparam vec_t  VEC_MAX  = {1'b0, {(VEC_WIDTH-1){1'b1}}};
	localparam vec_t  VEC_MIN  = {1'b1, {(VEC_WIDTH-1){1'b0}}};
	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic [8:0] DIAG_MASK = 9'b100010001;

	localparam logic [IDX_W-1:0] LAST_COMPOSE = IDX_W'(8);
	localparam logic [IDX_W-1:0] LAST_VECTOR  = IDX_W'(2);

	localparam logic [2:0] MODE_IDENT     = 3'd0;
	localparam logic [2:0] MODE_POST      = 3'd1;
	localparam logic [2:0] MODE_PRE       = 3'd2;
	localparam logic [2:0] MODE_TRANSPOSE = 3'd3;
	localparam logic [2:0] MODE_FLIP      = 3'd4;
	localparam logic [2:0] MODE_VECTOR    = 3'd5;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic [1:0] {
		KIND_SIMPLE,
		KIND_COMPOSE,
		KIND_VECTOR
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIMPLE,
		ST_MUL,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             accept;
		logic             simple;
		logic             issue;
		logic [IDX_W-1:0] idx;
		logic             commit;
		logic             load_out;
	} rmca_cmd_t;

	function automatic kind_t op_kind(logic [2:0] mode, logic [1:0] axis);
		kind_t k;
		k = KIND_SIMPLE;
		if ((mode == MODE_POST || mode == MODE_PRE) &&
		    (axis == AXIS_X || axis == AXIS_Y || axis == AXIS_Z))
			k = KIND_COMPOSE;
		else if (mode == MODE_VECTOR)
			k = KIND_VECTOR;
		return k;
	endfunction

	// row major position of entry (r, c)
	function automatic logic [IDX_W-1:0] mat_idx(logic [1:0] r, logic [1:0] c);
		logic [IDX_W-1:0] base;
		case (r)
			2'd0:    base = IDX_W'(0);
			2'd1:    base = IDX_W'(3);
			default: base = IDX_W'(6);
		endcase
		return base + IDX_W'(c);
	endfunction

	function automatic logic [1:0] row_of(logic [IDX_W-1:0] idx);
		logic [1:0] r;
		case (idx)
			4'd0, 4'd1, 4'd2: r = 2'd0;
			4'd3, 4'd4, 4'd5: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] col_of(logic [IDX_W-1:0] idx);
		logic [1:0] c;
		case (idx)
			4'd0, 4'd3, 4'd6: c = 2'd0;
			4'd1, 4'd4, 4'd7: c = 2'd1;
			default:          c = 2'd2;
		endcase
		return c;
	endfunction

	// entries negated by a half turn about the axis
	function automatic logic [8:0] flip_mask(logic [1:0] axis);
		logic [8:0] m;
		case (axis)
			AXIS_X:  m = 9'b001001110;
			AXIS_Y:  m = 9'b010101010;
			AXIS_Z:  m = 9'b011100100;
			default: m = 9'b000000000;
		endcase
		return m;
	endfunction

	// entry n of the axis rotation built from cosine and sine
	function automatic coef_t rot_entry(logic [1:0] axis, logic [IDX_W-1:0] n,
	                                    mat_t c, mat_t s);
		coef_t cw;
		coef_t sw;
		coef_t nsw;
		coef_t e;
		cw  = coef_t'(c);
		sw  = coef_t'(s);
		nsw = -sw;
		e   = '0;
		case (axis)
			AXIS_X: begin
				case (n)
					4'd0:    e = COEF_ONE;
					4'd4:    e = cw;
					4'd5:    e = sw;
					4'd7:    e = nsw;
					4'd8:    e = cw;
					default: e = '0;
				endcase
			end
			AXIS_Y: begin
				case (n)
					4'd0:    e = cw;
					4'd2:    e = nsw;
					4'd4:    e = COEF_ONE;
					4'd6:    e = sw;
					4'd8:    e = cw;
					default: e = '0;
				endcase
			end
			AXIS_Z: begin
				case (n)
					4'd0:    e = cw;
					4'd1:    e = sw;
					4'd3:    e = nsw;
					4'd4:    e = cw;
					4'd8:    e = COEF_ONE;
					default: e = '0;
				endcase
			end
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

[hw/rtl/rmca_ctrl.sv]
// ---------------------------------------------------------------------------
// rmca_ctrl
// sequencer: accepts a word, steps the dot product unit, hands off results
// ---------------------------------------------------------------------------
module rmca_ctrl import rmca_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] mode,
	input  logic [1:0] axis,
	output logic       out_valid,
	input  logic       out_ready,
	output rmca_cmd_t  cmd
);

	state_t           state_q, state_d;
	kind_t            kind_q, kind_d;
	logic [IDX_W-1:0] step_q, step_d;
	logic [IDX_W-1:0] last_step;
	logic             out_valid_q;
	kind_t            new_kind;

	assign new_kind  = op_kind(mode, axis);
	assign last_step = (kind_q == KIND_COMPOSE) ? LAST_COMPOSE : LAST_VECTOR;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KIND_SIMPLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			step_q  <= step_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		step_d  = step_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					kind_d     = new_kind;
					step_d     = '0;
					state_d    = (new_kind == KIND_SIMPLE) ? ST_SIMPLE : ST_MUL;
				end
			end
			ST_SIMPLE: begin
				cmd.simple = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_MUL: begin
				cmd.issue = 1'b1;
				cmd.idx   = step_q;
				if (step_q == last_step)
					state_d = ST_DRAIN;
				else
					step_d = step_q + IDX_W'(1);
			end
			ST_DRAIN: begin
				cmd.commit = (kind_q == KIND_COMPOSE);
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[hw/rtl/rmca_dp.sv]
// ---------------------------------------------------------------------------
// rmca_dp
// matrix store, three-lane multiply and round unit, output register
// ---------------------------------------------------------------------------
module rmca_dp import rmca_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rmca_cmd_t            cmd,
	input  logic [2:0]           mode,
	input  logic [1:0]           axis,
	input  logic signed [MAT_W-1:0]     cosine,
	input  logic signed [MAT_W-1:0]     sine,
	input  logic signed [VEC_WIDTH-1:0] vec_x,
	input  logic signed [VEC_WIDTH-1:0] vec_y,
	input  logic signed [VEC_WIDTH-1:0] vec_z,
	output logic signed [VEC_WIDTH-1:0] out_x,
	output logic signed [VEC_WIDTH-1:0] out_y,
	output logic signed [VEC_WIDTH-1:0] out_z,
	output logic                 is_identity,
	output logic                 is_axis_x,
	output logic                 is_axis_y,
	output logic                 is_axis_z,
	output logic                 saturated
);

	// latched word
	logic [2:0] mode_q;
	logic [1:0] axis_q;
	mat_t       cos_q, sin_q;
	vec_t       vin_q [3];

	mat_t       matrix_q [9];
	mat_t       t_q [9];
	vec_t       vec_q [3];
	logic       flag_q;

	mat_t       simple_next [9];
	logic       flip_sat;
	logic [8:0] fmask;
	coef_t      rot [9];

	logic [1:0] row_i, col_j;
	mat_t       opa [3];
	logic signed [OPB_W-1:0] opb [3];

	logic signed [PROD_W-1:0] p_s1 [3];
	logic [IDX_W-1:0]         idx_s1;
	logic                     valid_s1;

	logic signed [PROD_W-1:0] p_half [3];
	logic signed [RND_W-1:0]  rnd [3];
	logic signed [SUM_W-1:0]  sum;
	mat_t                     mat_val;
	vec_t                     vec_val;
	logic                     mat_clip, vec_clip;
	logic                     is_vec;

	assign is_vec = (mode_q == MODE_VECTOR);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q   <= mode;
			axis_q   <= axis;
			cos_q    <= cosine;
			sin_q    <= sine;
			vin_q[0] <= vec_x;
			vin_q[1] <= vec_y;
			vin_q[2] <= vec_z;
		end
	end

	// rotation operand
	always_comb begin
		for (int n = 0; n < 9; n++)
			rot[n] = rot_entry(axis_q, IDX_W'(n), cos_q, sin_q);
	end

	// next matrix for the modes that need no multiply
	always_comb begin
		simple_next = matrix_q;
		flip_sat    = 1'b0;
		fmask       = flip_mask(axis_q);
		unique case (mode_q)
			MODE_IDENT: begin
				for (int n = 0; n < 9; n++)
					simple_next[n] = DIAG_MASK[n] ? MAT_ONE : MAT_ZERO;
			end
			MODE_TRANSPOSE: begin
				for (int r = 0; r < 3; r++)
					for (int c = 0; c < 3; c++)
						simple_next[r*3+c] = matrix_q[c*3+r];
			end
			MODE_FLIP: begin
				for (int n = 0; n < 9; n++) begin
					if (fmask[n]) begin
						if (matrix_q[n] == MAT_MIN) begin
							simple_next[n] = MAT_MAX;
							flip_sat       = 1'b1;
						end else begin
							simple_next[n] = -matrix_q[n];
						end
					end
				end
			end
			default: ;
		endcase
	end

	// operand fetch for one matrix entry or one vector component
	assign row_i = is_vec ? cmd.idx[1:0] : row_of(cmd.idx);
	assign col_j = col_of(cmd.idx);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (mode_q == MODE_PRE) begin
				opa[k] = matrix_q[mat_idx(2'(k), col_j)];
				opb[k] = OPB_W'(rot[mat_idx(row_i, 2'(k))]);
			end else if (is_vec) begin
				opa[k] = matrix_q[mat_idx(row_i, 2'(k))];
				opb[k] = OPB_W'(vin_q[k]);
			end else begin
				opa[k] = matrix_q[mat_idx(row_i, 2'(k))];
				opb[k] = OPB_W'(rot[mat_idx(2'(k), col_j)]);
			end
		end
	end

	// stage 1: three products
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++)
			p_s1[k] <= PROD_W'(opa[k]) * PROD_W'(opb[k]);
		idx_s1 <= cmd.idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= cmd.issue;
	end

	// stage 2: round half up, sum, saturate
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			p_half[k] = p_s1[k] + RND_HALF;
			rnd[k]    = p_half[k][PROD_W-1:COEF_FRAC_BITS];
		end
		sum = SUM_W'(rnd[0]) + SUM_W'(rnd[1]) + SUM_W'(rnd[2]);

		mat_clip = 1'b1;
		if (sum > SUM_W'(MAT_MAX))
			mat_val = MAT_MAX;
		else if (sum < SUM_W'(MAT_MIN))
			mat_val = MAT_MIN;
		else begin
			mat_val  = sum[MAT_W-1:0];
			mat_clip = 1'b0;
		end

		vec_clip = 1'b1;
		if (sum > SUM_W'(VEC_MAX))
			vec_val = VEC_MAX;
		else if (sum < SUM_W'(VEC_MIN))
			vec_val = VEC_MIN;
		else begin
			vec_val  = sum[VEC_WIDTH-1:0];
			vec_clip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && !is_vec)
			t_q[idx_s1] <= mat_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 9; n++)
				matrix_q[n] <= DIAG_MASK[n] ? MAT_ONE : MAT_ZERO;
			for (int k = 0; k < 3; k++)
				vec_q[k] <= '0;
			flag_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				for (int k = 0; k < 3; k++)
					vec_q[k] <= '0;
				flag_q <= 1'b0;
			end else begin
				if (valid_s1 && is_vec)
					vec_q[idx_s1[1:0]] <= vec_val;
				if ((valid_s1 && (is_vec ? vec_clip : mat_clip)) ||
				    (cmd.simple && flip_sat))
					flag_q <= 1'b1;
			end
			if (cmd.simple)
				matrix_q <= simple_next;
			else if (cmd.commit) begin
				// last entry arrives from the sum stage in this same cycle
				for (int n = 0; n < 8; n++)
					matrix_q[n] <= t_q[n];
				matrix_q[8] <= mat_val;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_x       <= vec_q[0];
			out_y       <= vec_q[1];
			out_z       <= vec_q[2];
			is_identity <= (matrix_q[0] == MAT_ONE) && (matrix_q[4] == MAT_ONE) &&
			               (matrix_q[8] == MAT_ONE);
			is_axis_x   <= (matrix_q[0] == MAT_ONE) && (matrix_q[1] == MAT_ZERO) &&
			               (matrix_q[2] == MAT_ZERO);
			is_axis_y   <= (matrix_q[3] == MAT_ZERO) && (matrix_q[4] == MAT_ONE) &&
			               (matrix_q[5] == MAT_ZERO);
			is_axis_z   <= (matrix_q[6] == MAT_ZERO) && (matrix_q[7] == MAT_ZERO) &&
			               (matrix_q[8] == MAT_ONE);
			saturated   <= flag_q;
		end
	end

endmodule

[hw/rtl/rotation_matrix_compose_apply_core.sv]
// ---------------------------------------------------------------------------
// rotation_matrix_compose_apply_core
// 3x3 fixed-point rotation matrix: compose with axis rotations, rotate vectors
// ---------------------------------------------------------------------------
// usage
// - input channel in_valid/in_ready carries one word: mode, axis, cosine, sine,
//   vec_x, vec_y, vec_z; output channel out_valid/out_ready returns one word
//   per input word: out_x/y/z plus matrix flags and saturated
// - one word is in flight at a time; in_ready is high only while idle
// - compose (modes 1, 2) forms all nine entries of the new matrix; rotate
//   vector (mode 5) forms the three components of the rotated vector
// - identity, transpose, half turn flip and unused codes need no multiply
// - a three-lane multiply unit forms one dot product (one matrix entry or one
//   vector component) per cycle; the products are registered, then rounded
//   and summed in the sum stage, and the result is loaded into the output
//   register
// - reset loads the identity matrix and empties the output register
// - a stalled receiver holds the result in the output register; the next word
//   is still accepted and computed, and waits only at the hand-off
// ---------------------------------------------------------------------------
module rotation_matrix_compose_apply_core import rmca_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  mode,
	input  logic [1:0]                  axis,
	input  logic signed [MAT_W-1:0]     cosine,
	input  logic signed [MAT_W-1:0]     sine,
	input  logic signed [VEC_WIDTH-1:0] vec_x,
	input  logic signed [VEC_WIDTH-1:0] vec_y,
	input  logic signed [VEC_WIDTH-1:0] vec_z,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [VEC_WIDTH-1:0] out_x,
	output logic signed [VEC_WIDTH-1:0] out_y,
	output logic signed [VEC_WIDTH-1:0] out_z,
	output logic                        is_identity,
	output logic                        is_axis_x,
	output logic                        is_axis_y,
	output logic                        is_axis_z,
	output logic                        saturated
);

	// commands from sequencer to datapath
	rmca_cmd_t cmd;

	// sequencer: handshakes and step counter
	rmca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.axis      (axis),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// datapath: matrix store, multiply lanes, result register
	rmca_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.mode        (mode),
		.axis        (axis),
		.cosine      (cosine),
		.sine        (sine),
		.vec_x       (vec_x),
		.vec_y       (vec_y),
		.vec_z       (vec_z),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.is_identity (is_identity),
		.is_axis_x   (is_axis_x),
		.is_axis_y   (is_axis_y),
		.is_axis_z   (is_axis_z),
		.saturated   (saturated)
	);

endmodule

[hw/rtl/rmca_checker.sv]
// ---------------------------------------------------------------------------
// rmca_checker
// port-level checks of the rotation matrix core, bound to the top level
// ---------------------------------------------------------------------------
`include "rotation_matrix_compose_apply_core_macros.svh"

module rmca_checker import rmca_pkg::*; (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic signed [VEC_WIDTH-1:0] out_x,
	input logic signed [VEC_WIDTH-1:0] out_y,
	input logic signed [VEC_WIDTH-1:0] out_z,
	input logic                        is_identity,
	input logic                        is_axis_x,
	input logic                        is_axis_y,
	input logic                        is_axis_z,
	input logic                        saturated
);

	// whole output word, vector and flags
	logic [3*VEC_WIDTH+4:0] out_word;

	assign out_word = {out_x, out_y, out_z, is_identity, is_axis_x, is_axis_y, is_axis_z,
	                   saturated};

	// a stalled result stays offered
	`RMCA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// a stalled result keeps its payload
	`RMCA_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_word))

	// one word in flight: busy right after an accept
	`RMCA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// three unit rows mean a unit diagonal
	`RMCA_ASSERT_NOW(a_rows_imply_identity, clk, arst_n, out_valid && is_axis_x && is_axis_y && is_axis_z, is_identity)

endmodule

bind rotation_matrix_compose_apply_core rmca_checker u_rmca_checker (.*);

[bench/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the rotation matrix compose and apply core: a short
// drill of edge words, then about a thousand random words (mostly real angle
// rotations and vector turns, some noise), each checked against a model of
// the matrix held here, with random idling on both channels and one long
// receiver stall
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rmca_pkg::*;

	// one input word and one output word, field by field
	typedef struct packed {
		logic [2:0] mode;
		logic [1:0] axis;
		mat_t       cosine;
		mat_t       sine;
		vec_t       vec_x;
		vec_t       vec_y;
		vec_t       vec_z;
	} word_in_t;

	typedef struct packed {
		vec_t out_x;
		vec_t out_y;
		vec_t out_z;
		logic is_identity;
		logic is_axis_x;
		logic is_axis_y;
		logic is_axis_z;
		logic saturated;
	} word_out_t;

	// drill row: typed rows carry an answer read straight off the spec
	typedef struct packed {
		logic      typed;
		word_in_t  stim;
		word_out_t want;
	} drill_t;

	localparam int        RANDOM_WORDS = 1000;
	localparam int        MAX_GAP      = 17;
	localparam int        HOLD_AT      = 250;   // result count where the receiver stalls
	localparam int        HOLD_CYCLES  = 300;
	localparam int        TAIL_CYCLES  = 40;    // long enough for a compose word to finish
	localparam longint    UNIT         = longint'(1) <<< COEF_FRAC_BITS;
	localparam mat_t      Q_NEG_ONE    = -18'sd65536;
	localparam logic [1:0] AXIS_NONE   = 2'd3;
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;

	// matrix entries negated by a half turn, per axis
	localparam int HALF_TURN_IDX [3][4] = '{'{1, 2, 3, 6}, '{1, 3, 5, 7}, '{2, 5, 6, 7}};

	// answer for any non-vector word while the matrix is identity
	localparam word_out_t AT_IDENT = '{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
	localparam word_out_t NO_WANT  = '0;

	localparam int DRILL_ROWS = 25;
	localparam drill_t DRILL [DRILL_ROWS] = '{
		// first word after reset: matrix is identity
		'{1'b1, '{MODE_IDENT, AXIS_X, MAT_ZERO, MAT_ZERO, 32'sd0, 32'sd0, 32'sd0}, AT_IDENT},
		// identity passes the vector through unchanged, extremes included
		'{1'b1, '{MODE_VECTOR, AXIS_X, MAT_ZERO, MAT_ZERO, VEC_MAX, VEC_MIN, 32'sd1},
			'{VEC_MAX, VEC_MIN, 32'sd1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}},
		// unused modes leave everything alone
		'{1'b1, '{MODE_SPARE6, AXIS_Y, MAT_MAX, MAT_MIN, VEC_MAX, VEC_MAX, VEC_MAX}, AT_IDENT},
		'{1'b1, '{MODE_SPARE7, AXIS_NONE, MAT_MIN, MAT_MAX, VEC_MIN, VEC_MIN, VEC_MIN},
			AT_IDENT},
		// axis code 3 is a no-op for compose and flip; transposing identity changes nothing
		'{1'b1, '{MODE_POST, AXIS_NONE, MAT_MIN, MAT_MIN, 32'sd0, 32'sd0, 32'sd0}, AT_IDENT},
		'{1'b1, '{MODE_PRE, AXIS_NONE, MAT_MAX, MAT_MIN, 32'sd0, 32'sd0, 32'sd0}, AT_IDENT},
		'{1'b1, '{MODE_FLIP, AXIS_NONE, MAT_ZERO, MAT_ZERO, 32'sd0, 32'sd0, 32'sd0}, AT_IDENT},
		'{1'b1, '{MODE_TRANSPOSE, AXIS_X, MAT_ZERO, MAT_ZERO, 32'sd0, 32'sd0, 32'sd0},
			AT_IDENT},
		// exact quarter and half turns about each axis, a transpose, a vector turn, a reset
		'{1'b0, '{MODE_POST, AXIS_X, MAT_ZERO, MAT_ONE, 32'sd0, 32'sd0, 32'sd0}, NO_WANT},
		'{1'b0, '{MODE_PRE, AXIS_Y, MAT_ZERO, MAT_ONE, 32'sd0, 32'sd0, 32'sd0}, NO_WANT},
		'{1'b0, '{MODE_POST, AXIS_Z, Q_NEG_ONE, MAT_ZERO, 32'sd0, 32'sd0, 32'sd0}, NO_WANT},
		'{1'b0, '{MODE_TRANSPOSE, AXIS_Z, MAT_ZERO, MAT_ZERO, 32'sd0, 32'sd0, 32'sd0},
			NO_WANT},
		'{1'b0, '{MODE_FLIP, AXIS_X, MAT_ZERO, MAT_ZERO, 32'sd0, 32'sd0, 32'sd0}, NO_WANT},
		'{1'b0, '{MODE_FLIP, AXIS_Y, MAT_ZERO, MAT_ZERO, 32'sd0, 32'sd0, 32'sd0}, NO_WANT},
		'{1'b0, '{MODE_FLIP, AXIS_Z, MAT_ZERO, MAT_ZERO, 32'sd0, 32'sd0, 32'sd0}, NO_WANT},
		'{1'b0, '{MODE_VECTOR, AXIS_X, MAT_ZERO, MAT_ZERO, 32'sd1, -32'sd1, VEC_MAX}, NO_WANT},
		'{1'b1, '{MODE_IDENT, AXIS_Z, MAT_MAX, MAT_MAX, 32'sd0, 32'sd0, 32'sd0}, AT_IDENT},
		// sine of -2.0 drives one entry to the most negative value, its mirror clips
		'{1'b0, '{MODE_POST, AXIS_Z, MAT_ZERO, MAT_MIN, 32'sd0, 32'sd0, 32'sd0}, NO_WANT},
		// negating the most negative entry clips to the largest positive
		'{1'b0, '{MODE_FLIP, AXIS_X, MAT_ZERO, MAT_ZERO, 32'sd0, 32'sd0, 32'sd0}, NO_WANT},
		// scaled matrix pushes the vector components into clipping
		'{1'b0, '{MODE_VECTOR, AXIS_X, MAT_ZERO, MAT_ZERO, VEC_MAX, VEC_MAX, VEC_MIN}, NO_WANT},
		'{1'b0, '{MODE_PRE, AXIS_X, MAT_MAX, MAT_MAX, 32'sd0, 32'sd0, 32'sd0}, NO_WANT},
		'{1'b0, '{MODE_POST, AXIS_Y, MAT_MIN, MAT_MAX, 32'sd0, 32'sd0, 32'sd0}, NO_WANT},
		'{1'b0, '{MODE_VECTOR, AXIS_Y, MAT_ZERO, MAT_ZERO, VEC_MIN, VEC_MIN, VEC_MIN}, NO_WANT},
		'{1'b1, '{MODE_IDENT, AXIS_Y, MAT_ZERO, MAT_ZERO, 32'sd0, 32'sd0, 32'sd0}, AT_IDENT},
		// cosine and sine both at +-1.0, the in-range limits
		'{1'b0, '{MODE_PRE, AXIS_Z, MAT_ONE, Q_NEG_ONE, 32'sd0, 32'sd0, 32'sd0}, NO_WANT}
	};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [2:0] mode;
	logic [1:0] axis;
	mat_t cosine;
	mat_t sine;
	vec_t vec_x;
	vec_t vec_y;
	vec_t vec_z;
	logic out_valid;
	logic out_ready;
	vec_t out_x;
	vec_t out_y;
	vec_t out_z;
	logic is_identity;
	logic is_axis_x;
	logic is_axis_y;
	logic is_axis_z;
	logic saturated;

	// matrix as this bench believes it is, row major, one Q.16 entry each
	longint    orient [9];
	bit        clip_hit;
	word_out_t due_outputs [$];
	int        errors = 0;

	rotation_matrix_compose_apply_core u_top (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop, several times the slowest legal run
	initial begin
		#5ms;
		$display("FAIL rotation_matrix_compose_apply_core");
		$finish;
	end

	function automatic void load_unit();
		foreach (orient[i])
			orient[i] = (i % 4 == 0) ? UNIT : 0;
	endfunction

	// product rounded half up to the coefficient fraction
	function automatic longint qmul(longint a, longint b);
		return (a * b + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
	endfunction

	// clip to w signed bits, remember that it happened
	function automatic longint clip(longint v, int w);
		longint top;
		top = (longint'(1) <<< (w - 1)) - 1;
		if (v > top) begin
			clip_hit = 1'b1;
			return top;
		end
		if (v < -top - 1) begin
			clip_hit = 1'b1;
			return -top - 1;
		end
		return v;
	endfunction

	// apply one word to the tracked matrix and work out the output word
	function automatic word_out_t track_orientation(word_in_t w);
		longint    rot [9];
		longint    cur [9];
		longint    nxt [9];
		longint    vin [3];
		longint    vout [3];
		longint    c;
		longint    s;
		longint    acc;
		longint    t;
		bit        on_axis;
		word_out_t r;
		r        = '0;
		clip_hit = 1'b0;
		c        = longint'($signed(w.cosine));
		s        = longint'($signed(w.sine));
		vin[0]   = longint'($signed(w.vec_x));
		vin[1]   = longint'($signed(w.vec_y));
		vin[2]   = longint'($signed(w.vec_z));
		vout     = '{0, 0, 0};
		on_axis  = (w.axis == AXIS_X || w.axis == AXIS_Y || w.axis == AXIS_Z);
		case (w.mode)
			MODE_IDENT: load_unit();
			MODE_POST, MODE_PRE: begin
				if (on_axis) begin
					foreach (rot[i])
						rot[i] = 0;
					case (w.axis)
						AXIS_X: begin
							rot[0] = UNIT; rot[4] = c; rot[5] = s; rot[7] = -s; rot[8] = c;
						end
						AXIS_Y: begin
							rot[0] = c; rot[2] = -s; rot[4] = UNIT; rot[6] = s; rot[8] = c;
						end
						default: begin
							rot[0] = c; rot[1] = s; rot[3] = -s; rot[4] = c; rot[8] = UNIT;
						end
					endcase
					cur = orient;
					for (int i = 0; i < 3; i++)
						for (int j = 0; j < 3; j++) begin
							acc = 0;
							for (int k = 0; k < 3; k++)
								if (w.mode == MODE_POST)
									acc += qmul(cur[i*3+k], rot[k*3+j]);
								else
									acc += qmul(rot[i*3+k], cur[k*3+j]);
							nxt[i*3+j] = clip(acc, MAT_W);
						end
					orient = nxt;
				end
			end
			MODE_TRANSPOSE: begin
				for (int i = 0; i < 3; i++)
					for (int k = i + 1; k < 3; k++) begin
						t             = orient[i*3+k];
						orient[i*3+k] = orient[k*3+i];
						orient[k*3+i] = t;
					end
			end
			MODE_FLIP: begin
				if (on_axis)
					for (int i = 0; i < 4; i++)
						orient[HALF_TURN_IDX[w.axis][i]] =
							clip(-orient[HALF_TURN_IDX[w.axis][i]], MAT_W);
			end
			MODE_VECTOR: begin
				for (int i = 0; i < 3; i++) begin
					acc = 0;
					for (int k = 0; k < 3; k++)
						acc += qmul(orient[i*3+k], vin[k]);
					vout[i] = clip(acc, VEC_WIDTH);
				end
			end
			default: ;
		endcase
		r.out_x       = vec_t'(vout[0]);
		r.out_y       = vec_t'(vout[1]);
		r.out_z       = vec_t'(vout[2]);
		r.is_identity = (orient[0] == UNIT && orient[4] == UNIT && orient[8] == UNIT);
		r.is_axis_x   = (orient[0] == UNIT && orient[1] == 0 && orient[2] == 0);
		r.is_axis_y   = (orient[3] == 0 && orient[4] == UNIT && orient[5] == 0);
		r.is_axis_z   = (orient[6] == 0 && orient[7] == 0 && orient[8] == UNIT);
		r.saturated   = clip_hit;
		return r;
	endfunction

	function automatic mat_t to_q(real v);
		real t;
		t = v * real'(UNIT);
		return mat_t'($rtoi(t >= 0.0 ? t + 0.5 : t - 0.5));
	endfunction

	// mostly genuine rotations and vector turns, a tenth pure noise
	function automatic word_in_t make_word();
		word_in_t w;
		int       pick;
		real      ang;
		w      = '0;
		pick   = $urandom_range(0, 99);
		w.axis = 2'($urandom_range(0, 2));
		if (pick < 10) begin
			// noise: any code, any coefficient, any vector
			w.mode   = 3'($urandom_range(0, 7));
			w.axis   = 2'($urandom_range(0, 3));
			w.cosine = mat_t'($urandom);
			w.sine   = mat_t'($urandom);
			w.vec_x  = vec_t'($urandom);
			w.vec_y  = vec_t'($urandom);
			w.vec_z  = vec_t'($urandom);
		end else begin
			if (pick < 15)
				w.mode = MODE_IDENT;
			else if (pick < 45)
				w.mode = MODE_POST;
			else if (pick < 70)
				w.mode = MODE_PRE;
			else if (pick < 77)
				w.mode = MODE_TRANSPOSE;
			else if (pick < 83)
				w.mode = MODE_FLIP;
			else
				w.mode = MODE_VECTOR;
			// a quarter of the angles are exact quarter turns
			if ($urandom_range(0, 3) == 0)
				ang = 90.0 * $urandom_range(0, 3);
			else
				ang = 0.1 * $urandom_range(0, 3599);
			ang      = ang * 3.14159265358979 / 180.0;
			w.cosine = to_q($cos(ang));
			w.sine   = to_q($sin(ang));
			if ($urandom_range(0, 1) == 0) begin
				w.vec_x = vec_t'($urandom);
				w.vec_y = vec_t'($urandom);
				w.vec_z = vec_t'($urandom);
			end else begin
				w.vec_x = vec_t'(int'($urandom_range(0, 2097152)) - 1048576);
				w.vec_y = vec_t'(int'($urandom_range(0, 2097152)) - 1048576);
				w.vec_z = vec_t'(int'($urandom_range(0, 2097152)) - 1048576);
			end
		end
		return w;
	endfunction

	// hold a word on the input until it is taken, then log what it should give
	task automatic offer(word_in_t w, int gap, bit typed, word_out_t want);
		word_out_t p;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode     <= w.mode;
		axis     <= w.axis;
		cosine   <= w.cosine;
		sine     <= w.sine;
		vec_x    <= w.vec_x;
		vec_y    <= w.vec_y;
		vec_z    <= w.vec_z;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		// the tracked matrix moves even when the answer is typed in
		p = track_orientation(w);
		due_outputs.push_back(typed ? want : p);
		@(negedge clk);
	endtask

	task automatic match(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// input side: drill, then random words, then drain and verdict
	initial begin : feed
		int  gap;
		bit  calm;
		calm     = 1'b0;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		mode     = MODE_IDENT;
		axis     = AXIS_X;
		cosine   = MAT_ZERO;
		sine     = MAT_ZERO;
		vec_x    = '0;
		vec_y    = '0;
		vec_z    = '0;
		load_unit();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int n = 0; n < DRILL_ROWS; n++)
			offer(DRILL[n].stim, $urandom_range(0, MAX_GAP), DRILL[n].typed, DRILL[n].want);
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// now and then a run of back-to-back words
			if (n % 40 == 0)
				calm = ($urandom_range(0, 2) == 0);
			gap = calm ? 0 : $urandom_range(0, MAX_GAP);
			offer(make_word(), gap, 1'b0, NO_WANT);
		end
		in_valid <= 1'b0;
		wait (due_outputs.size() == 0);
		// let any stray word show up before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && due_outputs.size() == 0)
			$display("PASS rotation_matrix_compose_apply_core");
		else
			$display("FAIL rotation_matrix_compose_apply_core");
		$finish;
	end

	// output side: random ready, one long stall, compare against the oldest due word
	initial begin : drain
		int        gap;
		int        n_taken;
		bit        calm;
		word_out_t got;
		word_out_t want;
		calm      = 1'b0;
		n_taken   = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (n_taken % 40 == 0)
				calm = ($urandom_range(0, 2) == 0);
			gap = calm ? 0 : $urandom_range(0, MAX_GAP);
			// long hold-off so the core fills and drops in_ready
			if (n_taken == HOLD_AT)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = '{out_x, out_y, out_z, is_identity, is_axis_x, is_axis_y, is_axis_z,
				saturated};
			if (due_outputs.size() == 0) begin
				$error("output word arrived with none pending");
				errors++;
			end else begin
				want = due_outputs.pop_front();
				match("out_x", longint'($signed(want.out_x)), longint'($signed(got.out_x)));
				match("out_y", longint'($signed(want.out_y)), longint'($signed(got.out_y)));
				match("out_z", longint'($signed(want.out_z)), longint'($signed(got.out_z)));
				match("is_identity", longint'(want.is_identity), longint'(got.is_identity));
				match("is_axis_x", longint'(want.is_axis_x), longint'(got.is_axis_x));
				match("is_axis_y", longint'(want.is_axis_y), longint'(got.is_axis_y));
				match("is_axis_z", longint'(want.is_axis_z), longint'(got.is_axis_z));
				match("saturated", longint'(want.saturated), longint'(got.saturated));
			end
			n_taken++;
			@(negedge clk);
		end
	end

endmodule
